@@ hw/rtl/ptdt_pkg.sv @@
// Shared types and constants of the periodic task dispatch table.
package ptdt_pkg;

    localparam int MAX_TASKS_DEF = 8;

    localparam logic [15:0] TICK_DIV_RESET = 16'd1;
    localparam logic [6:0]  DISABLED_PRIO  = 7'd99;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_ADD    = 2'd1,
        OP_REMOVE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE,
        ST_SORT
    } state_t;

    typedef struct packed {
        logic [15:0] period;
        logic [15:0] remaining;
        logic [6:0]  prio;
        logic [7:0]  id;
    } entry_t;

    typedef struct packed {
        logic        rotate;
        logic        walk;
        logic        cmp;
        logic        add;
        logic        remove;
        logic [15:0] period;
        logic [6:0]  prio;
        logic [7:0]  id;
    } tbl_cmd_t;

    typedef struct packed {
        logic       fire;
        logic       swap;
        logic [7:0] id;
    } head_stat_t;

endpackage

@@ hw/rtl/ptdt_table.sv @@
// Rotating task table with one shared decrement and compare unit at its head.
module ptdt_table #(
    parameter int NUM = ptdt_pkg::MAX_TASKS_DEF,
    localparam int IDX_W = (NUM > 1) ? $clog2(NUM) : 1,
    localparam int CNT_W = $clog2(NUM + 1)
) (
    input  logic                 clk,
    input  ptdt_pkg::tbl_cmd_t   cmd,
    input  logic [IDX_W-1:0]     add_idx,
    input  logic [CNT_W-1:0]     used,
    output ptdt_pkg::head_stat_t stat
);

    localparam int SECOND = (NUM > 1) ? 1 : 0;

    ptdt_pkg::entry_t tbl_reg  [NUM];
    ptdt_pkg::entry_t tbl_next [NUM];

    ptdt_pkg::entry_t head;
    ptdt_pkg::entry_t nxt;
    ptdt_pkg::entry_t head_upd;
    ptdt_pkg::entry_t new_ent;
    logic [15:0]      dec;
    logic             fire_now;
    logic             swap_now;

    // Shared unit: count down the head entry, or compare the head pair
    always_comb
    begin
        head     = tbl_reg[0];
        nxt      = tbl_reg[SECOND];
        dec      = head.remaining - 16'd1;
        fire_now = cmd.walk && (dec == 16'd0) && (head.prio != ptdt_pkg::DISABLED_PRIO);
        swap_now = cmd.cmp && (head.prio < nxt.prio);
        head_upd = head;
        if (cmd.walk)
        begin
            head_upd.remaining = fire_now ? head.period : dec;
        end
        stat.fire = fire_now;
        stat.swap = swap_now;
        stat.id   = head.id;
    end

    always_comb
    begin
        new_ent.period    = cmd.period;
        new_ent.remaining = cmd.period;
        new_ent.prio      = cmd.prio;
        new_ent.id        = cmd.id;
        for (int i = 0; i < NUM; i++)
        begin
            tbl_next[i] = tbl_reg[i];
        end
        if (cmd.rotate)
        begin
            for (int i = 0; i < NUM; i++)
            begin
                tbl_next[i] = tbl_reg[(i + 1) % NUM];
            end
            // the larger of the head pair drops to the tail, the smaller moves on
            if (swap_now)
            begin
                tbl_next[NUM-1] = nxt;
                tbl_next[0]     = head;
            end
            else
            begin
                tbl_next[NUM-1] = head_upd;
            end
        end
        if (cmd.add)
        begin
            for (int i = 0; i < NUM; i++)
            begin
                if (IDX_W'(i) == add_idx)
                begin
                    tbl_next[i] = new_ent;
                end
            end
        end
        if (cmd.remove)
        begin
            for (int i = 0; i < NUM; i++)
            begin
                if ((CNT_W'(i) < used) && (tbl_reg[i].id == cmd.id))
                begin
                    tbl_next[i].prio = ptdt_pkg::DISABLED_PRIO;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NUM; i++)
        begin
            tbl_reg[i] <= tbl_next[i];
        end
    end

endmodule

@@ hw/rtl/periodic_task_dispatch_table_core.sv @@
// Top level of the periodic task dispatch table: sequencer, prescaler and result register.
//
// Usage:
//   Requests enter on start/op/period/priority_req/task_id and are taken at a
//   clock edge where start is high and busy is low. op selects a raw tick, an
//   add or a remove by id. Results leave on accepted/fired/fired_id/last, each
//   shown for exactly one cycle with strobe high; the receiver cannot stall
//   them. last marks the final result of a request.
//   tick_divider is written through cfg_valid/cfg_data; cfg_ready is always
//   high. Write it only while the block is idle.
// Timing:
//   Add, remove, an unused op and a raw tick that does not complete a
//   scheduler tick: one result in the cycle after the request. A scheduler
//   tick rotates the whole table past the shared count-down unit, one entry
//   per cycle, with busy held throughout; fired ids stream out in table
//   order, and the final result comes in the same cycle that busy drops.
//   An add is followed by bubble-sort passes, each a full rotation of the
//   table, up to one pass per used entry, with busy held throughout.
// Reset:
//   rst_n clears the sequencer, prescaler, used count and tick_divider (to 1).
//   Table entries beyond the used count are never read, so need no clearing.
module periodic_task_dispatch_table_core #(
    parameter int MAX_TASKS = ptdt_pkg::MAX_TASKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  op,
    input  logic [15:0] period,
    input  logic [6:0]  priority_req,
    input  logic [7:0]  task_id,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data,
    output logic        strobe,
    output logic        accepted,
    output logic        fired,
    output logic [7:0]  fired_id,
    output logic        last
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    ptdt_pkg::state_t     state_reg, state_next;
    logic [IDX_W-1:0]     step_reg, step_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [15:0]          pcount_reg, pcount_next;
    logic [15:0]          tdiv_reg;
    logic                 swapped_reg, swapped_next;
    logic                 pend_reg, pend_next;
    logic [7:0]           pend_id_reg, pend_id_next;

    logic                 strobe_reg, strobe_next;
    logic                 acc_reg, acc_next;
    logic                 fired_reg, fired_next;
    logic [7:0]           id_reg, id_next;
    logic                 last_reg, last_next;

    ptdt_pkg::tbl_cmd_t   cmd;
    ptdt_pkg::head_stat_t stat;
    logic [15:0]          pcount_inc;
    logic                 last_step;

    assign busy      = (state_reg != ptdt_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign strobe    = strobe_reg;
    assign accepted  = acc_reg;
    assign fired     = fired_reg;
    assign fired_id  = id_reg;
    assign last      = last_reg;

    assign pcount_inc = pcount_reg + 16'd1;
    assign last_step  = (step_reg == IDX_W'(MAX_TASKS - 1));

    ptdt_table #(
        .NUM (MAX_TASKS)
    ) u_table (
        .clk     (clk),
        .cmd     (cmd),
        .add_idx (used_reg[IDX_W-1:0]),
        .used    (used_reg),
        .stat    (stat)
    );

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        used_next    = used_reg;
        pcount_next  = pcount_reg;
        swapped_next = swapped_reg;
        pend_next    = pend_reg;
        pend_id_next = pend_id_reg;

        strobe_next  = 1'b0;
        acc_next     = 1'b1;
        fired_next   = 1'b0;
        id_next      = 8'd0;
        last_next    = 1'b1;

        cmd          = '0;
        cmd.period   = period;
        cmd.prio     = priority_req;
        cmd.id       = task_id;

        unique case (state_reg)
            ptdt_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    strobe_next = 1'b1;
                    unique case (op)
                        ptdt_pkg::OP_TICK:
                        begin
                            if (pcount_inc == tdiv_reg)
                            begin
                                // scheduler tick: walk the table, report later
                                pcount_next = 16'd0;
                                strobe_next = 1'b0;
                                pend_next   = 1'b0;
                                step_next   = '0;
                                state_next  = ptdt_pkg::ST_WALK;
                            end
                            else
                            begin
                                pcount_next = pcount_inc;
                            end
                        end
                        ptdt_pkg::OP_ADD:
                        begin
                            if (used_reg >= CNT_W'(MAX_TASKS))
                            begin
                                acc_next = 1'b0;
                            end
                            else
                            begin
                                // append, then sort the used entries again
                                cmd.add      = 1'b1;
                                used_next    = used_reg + 1'b1;
                                step_next    = '0;
                                swapped_next = 1'b0;
                                state_next   = ptdt_pkg::ST_SORT;
                            end
                        end
                        ptdt_pkg::OP_REMOVE:
                        begin
                            cmd.remove = 1'b1;
                        end
                        default:
                        begin
                            // unused op: answer only
                        end
                    endcase
                end
            end

            ptdt_pkg::ST_WALK:
            begin
                cmd.rotate = 1'b1;
                cmd.walk   = (CNT_W'(step_reg) < used_reg);
                if (stat.fire)
                begin
                    // hold the newest fire, release the one before it
                    if (pend_reg)
                    begin
                        strobe_next = 1'b1;
                        fired_next  = 1'b1;
                        id_next     = pend_id_reg;
                        last_next   = 1'b0;
                    end
                    pend_next    = 1'b1;
                    pend_id_next = stat.id;
                end
                step_next = step_reg + 1'b1;
                if (last_step)
                begin
                    step_next  = '0;
                    state_next = ptdt_pkg::ST_DONE;
                end
            end

            ptdt_pkg::ST_DONE:
            begin
                strobe_next = 1'b1;
                fired_next  = pend_reg;
                id_next     = pend_reg ? pend_id_reg : 8'd0;
                pend_next   = 1'b0;
                state_next  = ptdt_pkg::ST_IDLE;
            end

            ptdt_pkg::ST_SORT:
            begin
                cmd.rotate = 1'b1;
                cmd.cmp    = ((CNT_W'(step_reg) + 1'b1) < used_reg);
                if (stat.swap)
                begin
                    swapped_next = 1'b1;
                end
                step_next = step_reg + 1'b1;
                if (last_step)
                begin
                    step_next    = '0;
                    swapped_next = 1'b0;
                    // another pass only if this one moved something
                    if (!(swapped_reg || stat.swap))
                    begin
                        state_next = ptdt_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = ptdt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ptdt_pkg::ST_IDLE;
            step_reg    <= '0;
            used_reg    <= '0;
            pcount_reg  <= 16'd0;
            tdiv_reg    <= ptdt_pkg::TICK_DIV_RESET;
            swapped_reg <= 1'b0;
            pend_reg    <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            used_reg    <= used_next;
            pcount_reg  <= pcount_next;
            swapped_reg <= swapped_next;
            pend_reg    <= pend_next;
            strobe_reg  <= strobe_next;
            if (cfg_valid && cfg_ready)
            begin
                tdiv_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_id_reg <= pend_id_next;
        acc_reg     <= acc_next;
        fired_reg   <= fired_next;
        id_reg      <= id_next;
        last_reg    <= last_next;
    end

endmodule

@@ bench/ptdt_dispatch_monitor.sv @@
// Monitor of the periodic task dispatch table: tracks the table, predicts and checks results.
`timescale 1ns / 1ps

module ptdt_dispatch_monitor #(
    parameter int MAX_TASKS = ptdt_pkg::MAX_TASKS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  op,
    input  logic [15:0] period,
    input  logic [6:0]  priority_req,
    input  logic [7:0]  task_id,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,
    input  logic        strobe,
    input  logic        accepted,
    input  logic        fired,
    input  logic [7:0]  fired_id,
    input  logic        last,
    output int          errors,
    output int          outstanding
);

    typedef struct packed {
        logic       accepted;
        logic       fired;
        logic [7:0] fired_id;
        logic       last;
    } dispatch_t;

    dispatch_t          due_results[$];
    ptdt_pkg::entry_t   slots[MAX_TASKS];
    logic [15:0]        divider;
    logic [15:0]        prescale;
    int                 used;
    int                 fail_count = 0;
    int                 due_count = 0;

    assign errors      = fail_count;
    assign outstanding = due_count;

    function automatic dispatch_t make_result(input logic acc, input logic fire,
                                              input logic [7:0] id, input logic fin);
        dispatch_t res;
        res.accepted = acc;
        res.fired    = fire;
        res.fired_id = id;
        res.last     = fin;
        return res;
    endfunction

    task automatic report_field(input string name, input logic [7:0] want,
                                input logic [7:0] got);
        if (want !== got)
        begin
            fail_count++;
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
        end
    endtask

    // Walk the table for one request and queue the results it causes.
    task automatic predict_dispatch(input logic [1:0] code, input logic [15:0] per,
                                    input logic [6:0] prio, input logic [7:0] id);
        dispatch_t        held;
        logic             have_held;
        ptdt_pkg::entry_t tmp;
        int               i;
        int               j;
        have_held = 1'b0;
        held      = '0;
        case (code)
            ptdt_pkg::OP_TICK:
            begin
                prescale = prescale + 16'd1;
                if (prescale == divider)
                begin
                    prescale = '0;
                    for (i = 0; i < used; i++)
                    begin
                        slots[i].remaining = slots[i].remaining - 16'd1;
                        if (slots[i].remaining == 16'd0 &&
                            slots[i].prio != ptdt_pkg::DISABLED_PRIO)
                        begin
                            slots[i].remaining = slots[i].period;
                            if (have_held)
                                due_results.push_back(held);
                            held      = make_result(1'b1, 1'b1, slots[i].id, 1'b0);
                            have_held = 1'b1;
                        end
                    end
                end
                if (have_held)
                begin
                    held.last = 1'b1;
                    due_results.push_back(held);
                end
                else
                    due_results.push_back(make_result(1'b1, 1'b0, 8'd0, 1'b1));
            end
            ptdt_pkg::OP_ADD:
            begin
                if (used >= MAX_TASKS)
                    due_results.push_back(make_result(1'b0, 1'b0, 8'd0, 1'b1));
                else
                begin
                    slots[used].period    = per;
                    slots[used].remaining = per;
                    slots[used].prio      = prio;
                    slots[used].id        = id;
                    used++;
                    // stable: only a strictly higher priority moves forward
                    for (i = 1; i < used; i++)
                        for (j = i; j > 0 && slots[j - 1].prio < slots[j].prio; j--)
                        begin
                            tmp          = slots[j - 1];
                            slots[j - 1] = slots[j];
                            slots[j]     = tmp;
                        end
                    due_results.push_back(make_result(1'b1, 1'b0, 8'd0, 1'b1));
                end
            end
            ptdt_pkg::OP_REMOVE:
            begin
                for (i = 0; i < used; i++)
                    if (slots[i].id == id)
                        slots[i].prio = ptdt_pkg::DISABLED_PRIO;
                due_results.push_back(make_result(1'b1, 1'b0, 8'd0, 1'b1));
            end
            default:
                due_results.push_back(make_result(1'b1, 1'b0, 8'd0, 1'b1));
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch_edge
        dispatch_t want;
        int        k;
        if (!rst_n)
        begin
            divider  = ptdt_pkg::TICK_DIV_RESET;
            prescale = '0;
            used     = 0;
            for (k = 0; k < MAX_TASKS; k++)
                slots[k] = '0;
            due_results.delete();
        end
        else
        begin
            if (strobe)
            begin
                if (due_results.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result with none expected: acc %0b fired %0b id %0h last %0b",
                             $time, accepted, fired, fired_id, last);
                end
                else
                begin
                    want = due_results.pop_front();
                    report_field("accepted", {7'd0, want.accepted}, {7'd0, accepted});
                    report_field("fired", {7'd0, want.fired}, {7'd0, fired});
                    report_field("fired_id", want.fired_id, fired_id);
                    report_field("last", {7'd0, want.last}, {7'd0, last});
                end
            end
            if (cfg_valid && cfg_ready)
                divider = cfg_data;
            if (start && !busy)
                predict_dispatch(op, period, priority_req, task_id);
        end
        due_count = due_results.size();
    end

endmodule

@@ bench/testbench.sv @@
// Top of the dispatch table bench: clock, reset, request stimulus and the verdict.
`timescale 1ns / 1ps

module testbench;

    localparam int         MAX_TASKS   = ptdt_pkg::MAX_TASKS_DEF;
    // Slowest request: an add followed by a full set of sort passes.
    localparam int         SETTLE      = (MAX_TASKS + 1) * MAX_TASKS + 8;
    localparam int         CYCLE_LIMIT = 400000;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [1:0]  op = ptdt_pkg::OP_TICK;
    logic [15:0] period = '0;
    logic [6:0]  priority_req = '0;
    logic [7:0]  task_id = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;
    logic        strobe;
    logic        accepted;
    logic        fired;
    logic [7:0]  fired_id;
    logic        last;
    int          fail_count;
    int          outstanding;
    int          idle_pct = 8;
    int          cycles = 0;

    periodic_task_dispatch_table_core #(
        .MAX_TASKS(MAX_TASKS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .period(period),
        .priority_req(priority_req),
        .task_id(task_id),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .strobe(strobe),
        .accepted(accepted),
        .fired(fired),
        .fired_id(fired_id),
        .last(last)
    );

    ptdt_dispatch_monitor #(
        .MAX_TASKS(MAX_TASKS)
    ) watch (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .period(period),
        .priority_req(priority_req),
        .task_id(task_id),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data(cfg_data),
        .strobe(strobe),
        .accepted(accepted),
        .fired(fired),
        .fired_id(fired_id),
        .last(last),
        .errors(fail_count),
        .outstanding(outstanding)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Watchdog: abandon the run if the block stops answering.
    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("periodic_task_dispatch_table_core: mismatch");
        $finish;
    end

    // Present one request and hold it until the block takes it. Idle gaps are
    // drawn first so that they land on every phase of the block's work; start
    // stays high across back-to-back requests and is only dropped for a gap.
    task automatic issue(input logic [1:0] code, input logic [15:0] per,
                         input logic [6:0] prio, input logic [7:0] id);
        while ($urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start        <= 1'b1;
        op           <= code;
        period       <= per;
        priority_req <= prio;
        task_id      <= id;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // Drop start, wait until every expected result has come and the block has
    // finished its sort passes, then let the tail of its latency run out.
    task automatic drain;
        @(negedge clk);
        start <= 1'b0;
        while (outstanding != 0 || busy !== 1'b0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    // Write tick_divider once the block is quiet.
    task automatic write_divider(input logic [15:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly raw ticks, so that the table keeps firing; the rest are adds
    // (rejected once the table is full), removes of mostly unknown ids and the
    // unused op. All fields carry random content whatever the op.
    task automatic random_requests(input int count);
        int         n;
        int         pick;
        logic [1:0] code;
        for (n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (pick < 78)
                code = ptdt_pkg::OP_TICK;
            else if (pick < 86)
                code = ptdt_pkg::OP_ADD;
            else if (pick < 94)
                code = ptdt_pkg::OP_REMOVE;
            else
                code = OP_UNUSED;
            issue(code, 16'($urandom_range(65535)), 7'($urandom_range(127)),
                  8'($urandom_range(255)));
        end
    endtask

    initial
    begin
        // Hold reset, then release it away from the rising edge.
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, tick_divider at its reset value of one.
        idle_pct = 8;
        issue(ptdt_pkg::OP_TICK, 16'd0, 7'd0, 8'd0);      // empty table: nothing fires
        issue(ptdt_pkg::OP_ADD, 16'd1, 7'd0, 8'h00);      // period of one, smallest priority and id
        issue(ptdt_pkg::OP_ADD, 16'hFFFF, 7'd127, 8'hFF); // largest fields, priority above 99
        issue(ptdt_pkg::OP_ADD, 16'd0, 7'd50, 8'h5A);     // zero period wraps on its first tick
        issue(ptdt_pkg::OP_ADD, 16'd3, ptdt_pkg::DISABLED_PRIO, 8'h07); // added already disabled
        issue(ptdt_pkg::OP_ADD, 16'd2, 7'd50, 8'hA5);     // tie: stays behind the earlier 50
        issue(ptdt_pkg::OP_TICK, 16'd0, 7'd0, 8'd0);
        issue(ptdt_pkg::OP_ADD, 16'd5, 7'd10, 8'h33);
        issue(ptdt_pkg::OP_REMOVE, 16'd0, 7'd0, 8'd200);  // unknown id: no change
        issue(ptdt_pkg::OP_REMOVE, 16'd0, 7'd0, 8'h33);
        issue(OP_UNUSED, 16'hA5A5, 7'h55, 8'hC3);
        issue(ptdt_pkg::OP_TICK, 16'd0, 7'd0, 8'd0);
        issue(ptdt_pkg::OP_ADD, 16'd4, 7'd64, 8'h11);
        issue(ptdt_pkg::OP_ADD, 16'd7, 7'd1, 8'h22);      // table now full
        issue(ptdt_pkg::OP_ADD, 16'd2, 7'd127, 8'hFF);    // full table: rejected
        repeat (7) issue(ptdt_pkg::OP_TICK, 16'd0, 7'd0, 8'd0);

        // Random phases: sender idles rarely, then often, then never.
        write_divider(16'd2);
        random_requests(130);

        idle_pct = 67;
        write_divider(16'd5);
        random_requests(130);

        // Extremes of the divider; lowering it to zero below the running
        // count leaves the prescaler to run on and wrap.
        idle_pct = 0;
        write_divider(16'hFFFF);
        random_requests(45);
        write_divider(16'd0);
        random_requests(45);

        drain();
        if (fail_count == 0)
            $display("periodic_task_dispatch_table_core: match");
        else
            $display("periodic_task_dispatch_table_core: mismatch");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/ptdt_pkg.sv
hw/rtl/ptdt_table.sv
hw/rtl/periodic_task_dispatch_table_core.sv
bench/ptdt_dispatch_monitor.sv
bench/testbench.sv
